// ===== rtl/cbsc_pkg.sv =====
// Shared types, constants and the arctangent table for the compass bearing pipeline.
package cbsc_pkg;

    localparam int CORDIC_STAGES_DEF     = 16;
    localparam int BEARING_FRAC_BITS_DEF = 7;
    localparam int ATAN_LEN              = 24;

    localparam int IN_W  = 16;
    localparam int OUT_W = 16;
    localparam int XW    = 34;   // CORDIC datapath, covers gain and sqrt(2) growth
    localparam int ANG_W = 32;   // binary angle, one turn = 2^32

    localparam logic signed [IN_W-1:0] STUCK_A = -16'sd16192;
    localparam logic signed [IN_W-1:0] STUCK_B = 16'sd16448;
    localparam logic signed [IN_W-1:0] STUCK_C = -16'sd32640;

    localparam logic [ANG_W-1:0] ANG_HALF = 32'h8000_0000;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic [ANG_W-1:0]     ang;
        logic                 zero;
        logic                 invalid;
    } t_vec;

    function automatic logic [ANG_W-1:0] atan_entry(input int idx);
        logic [ANG_W-1:0] v;
        case (idx)
            0:       v = 32'h20000000;
            1:       v = 32'h12E4051E;
            2:       v = 32'h09FB385B;
            3:       v = 32'h051111D4;
            4:       v = 32'h028B0D43;
            5:       v = 32'h0145D7E1;
            6:       v = 32'h00A2F61E;
            7:       v = 32'h00517C55;
            8:       v = 32'h0028BE53;
            9:       v = 32'h00145F2F;
            10:      v = 32'h000A2F98;
            11:      v = 32'h000517CC;
            12:      v = 32'h00028BE6;
            13:      v = 32'h000145F3;
            14:      v = 32'h0000A2FA;
            15:      v = 32'h0000517D;
            16:      v = 32'h000028BE;
            17:      v = 32'h0000145F;
            18:      v = 32'h00000A30;
            19:      v = 32'h00000518;
            20:      v = 32'h0000028C;
            21:      v = 32'h00000146;
            22:      v = 32'h000000A3;
            23:      v = 32'h00000051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/cbsc_prep.sv =====
// Front end: half-plane fold, stuck check, magnitude normalization (three stages).
module cbsc_prep
    import cbsc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic signed [IN_W-1:0] i_x,
    input  logic signed [IN_W-1:0] i_y,
    input  logic signed [IN_W-1:0] i_z,
    output logic                   o_valid,
    output t_vec                   o_vec
);

    // stage 1
    logic                   r_v1;
    logic signed [IN_W:0]   r_xn, n_xn;
    logic signed [IN_W:0]   r_yn, n_yn;
    logic [IN_W-1:0]        r_m, n_m;
    logic [ANG_W-1:0]       r_ang1;
    logic                   r_zero1, r_inv1, n_inv;
    logic signed [IN_W:0]   xe, ye, ay;

    always_comb begin
        xe   = {i_x[IN_W-1], i_x};
        ye   = {i_y[IN_W-1], i_y};
        n_xn = i_x[IN_W-1] ? -xe : xe;
        n_yn = i_x[IN_W-1] ? -ye : ye;
        ay   = n_yn[IN_W] ? -n_yn : n_yn;
        n_m  = (n_xn > ay) ? n_xn[IN_W-1:0] : ay[IN_W-1:0];
        n_inv = (i_x == i_y) && (i_y == i_z) &&
                ((i_x == STUCK_A) || (i_x == STUCK_B) || (i_x == STUCK_C) || (i_x == '0));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xn    <= n_xn;
            r_yn    <= n_yn;
            r_m     <= n_m;
            r_ang1  <= i_x[IN_W-1] ? ANG_HALF : '0;
            r_zero1 <= (i_x == '0) && (i_y == '0);
            r_inv1  <= n_inv;
        end
    end

    // stage 2: shift amount from leading one
    logic                   r_v2;
    logic signed [IN_W:0]   r_xn2, r_yn2;
    logic [4:0]             r_s, n_s;
    logic [ANG_W-1:0]       r_ang2;
    logic                   r_zero2, r_inv2;

    always_comb begin
        int msb;
        msb = 0;
        for (int k = 0; k < IN_W; k++) begin
            if (r_m[k]) msb = k;
        end
        n_s = 5'(29 - msb);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xn2   <= r_xn;
            r_yn2   <= r_yn;
            r_s     <= n_s;
            r_ang2  <= r_ang1;
            r_zero2 <= r_zero1;
            r_inv2  <= r_inv1;
        end
    end

    // stage 3: normalize
    logic                 r_v3;
    t_vec                 r_vec;
    logic signed [XW-1:0] xw, yw;

    always_comb begin
        xw = {{(XW-IN_W-1){r_xn2[IN_W]}}, r_xn2};
        yw = {{(XW-IN_W-1){r_yn2[IN_W]}}, r_yn2};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vec.x       <= xw <<< r_s;
            r_vec.y       <= yw <<< r_s;
            r_vec.ang     <= r_ang2;
            r_vec.zero    <= r_zero2;
            r_vec.invalid <= r_inv2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign o_valid = r_v3;
    assign o_vec   = r_vec;

endmodule

// ===== rtl/cbsc_cordic_stage.sv =====
// One registered CORDIC vectoring iteration.
module cbsc_cordic_stage
    import cbsc_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_vec i_vec,
    output logic o_valid,
    output t_vec o_vec
);

    localparam logic [ANG_W-1:0] ATAN_I = atan_entry(IDX);

    logic                 r_valid;
    t_vec                 r_vec, n_vec;
    logic signed [XW-1:0] xs, ys;

    always_comb begin
        xs    = i_vec.x >>> IDX;
        ys    = i_vec.y >>> IDX;
        n_vec = i_vec;
        if (!i_vec.y[XW-1]) begin
            n_vec.x   = i_vec.x + ys;
            n_vec.y   = i_vec.y - xs;
            n_vec.ang = i_vec.ang + ATAN_I;
        end else begin
            n_vec.x   = i_vec.x - ys;
            n_vec.y   = i_vec.y + xs;
            n_vec.ang = i_vec.ang - ATAN_I;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_vec <= n_vec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    assign o_valid = r_valid;
    assign o_vec   = r_vec;

endmodule

// ===== rtl/cbsc_scale.sv =====
// Back end: binary angle to degrees, rounding and full-turn wrap (two stages).
module cbsc_scale
    import cbsc_pkg::*;
#(
    parameter int BEARING_FRAC_BITS = BEARING_FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  t_vec             i_vec,
    output logic             o_valid,
    output logic [OUT_W-1:0] o_bearing,
    output logic             o_invalid
);

    localparam int FULL_W = 17;
    localparam int PROD_W = ANG_W + FULL_W;
    localparam logic [FULL_W-1:0] FULL = FULL_W'(360 << BEARING_FRAC_BITS);
    localparam logic [PROD_W-1:0] HALF_LSB = PROD_W'(ANG_HALF);

    logic              r_v1, r_v2;
    logic [PROD_W-1:0] r_prod;
    logic              r_zero1, r_inv1;
    logic [OUT_W-1:0]  r_bearing, n_bearing;
    logic              r_inv2;
    logic [PROD_W-1:0] rnd;
    logic [FULL_W-1:0] b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod  <= {{FULL_W{1'b0}}, i_vec.ang} * {{ANG_W{1'b0}}, FULL};
            r_zero1 <= i_vec.zero;
            r_inv1  <= i_vec.invalid;
        end
    end

    always_comb begin
        rnd = r_prod + HALF_LSB;
        b   = rnd[PROD_W-1:ANG_W];
        n_bearing = (r_zero1 || (b >= FULL)) ? '0 : b[OUT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bearing <= n_bearing;
            r_inv2    <= r_inv1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    assign o_valid   = r_v2;
    assign o_bearing = r_bearing;
    assign o_invalid = r_inv2;

endmodule

// ===== rtl/compass_bearing_with_stuck_check_top.sv =====
// Compass bearing: atan2(y, x) in 1/2^F degree via pipelined CORDIC, plus stuck-axis flag.
//
// Input stream: one transfer per magnetometer sample, tdata = {z, y, x}, 16-bit signed each.
// Output stream: one transfer per sample, in order. tdata = bearing (unsigned, 0 up to
// just under 360 degrees in 1/2^BEARING_FRAC_BITS steps); tuser = invalid_reading flag,
// set when x, y and z all equal one of the four stuck patterns.
// Pipeline: 3 front-end stages, one per CORDIC iteration, 2 for scaling and rounding.
// Throughput: one sample per cycle while the pipeline is not stalled; every iteration has its own adder stage.
// Iterations beyond the 24-entry arctangent table are not built.
// Stall: all stages share one enable. When the output holds a transfer and the receiver
// drops tready, the pipeline freezes and o_s_tready falls in the same cycle; nothing is
// lost or repeated. While the output register is empty or being drained, a new sample
// is taken every cycle.
// Reset: synchronous, active low; clears all stage valid bits, output tvalid goes low.
module compass_bearing_with_stuck_check_top
    import cbsc_pkg::*;
#(
    parameter int CORDIC_STAGES     = CORDIC_STAGES_DEF,
    parameter int BEARING_FRAC_BITS = BEARING_FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // mag_x [15:0], mag_y [31:16], mag_z [47:32]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // bearing [15:0]
    output logic        o_m_tuser    // invalid_reading [0]
);

    localparam int NSTG = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

    logic en;
    logic out_valid;
    logic stg_valid [NSTG+1];
    t_vec stg_vec   [NSTG+1];

    assign en         = !out_valid || i_m_tready;
    assign o_s_tready = en;

    cbsc_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_tvalid),
        .i_x     (i_s_tdata[15:0]),
        .i_y     (i_s_tdata[31:16]),
        .i_z     (i_s_tdata[47:32]),
        .o_valid (stg_valid[0]),
        .o_vec   (stg_vec[0])
    );

    for (genvar g = 0; g < NSTG; g++) begin : g_cordic
        cbsc_cordic_stage #(
            .IDX (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (stg_valid[g]),
            .i_vec   (stg_vec[g]),
            .o_valid (stg_valid[g+1]),
            .o_vec   (stg_vec[g+1])
        );
    end

    cbsc_scale #(
        .BEARING_FRAC_BITS (BEARING_FRAC_BITS)
    ) u_scale (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (stg_valid[NSTG]),
        .i_vec     (stg_vec[NSTG]),
        .o_valid   (out_valid),
        .o_bearing (o_m_tdata),
        .o_invalid (o_m_tuser)
    );

    assign o_m_tvalid = out_valid;

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for the CORDIC compass bearing block with stuck-sensor flag.
`timescale 1ns / 1ps

module tb_top;

    localparam int STAGES    = 16;
    localparam int FRAC_BITS = 7;
    localparam int LATENCY   = STAGES + 5;
    localparam longint unsigned FULL_TURN = 64'd360 << FRAC_BITS;
    localparam logic [31:0] HALF_TURN = 32'h8000_0000;

    localparam logic signed [15:0] STUCK_NEG_MID  = -16'sd16192;
    localparam logic signed [15:0] STUCK_POS_MID  = 16'sd16448;
    localparam logic signed [15:0] STUCK_NEG_HIGH = -16'sd32640;

    localparam logic [31:0] ATAN_BAM [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct {
        logic [15:0] bearing;
        logic        invalid;
    } t_heading;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;     // mag_x [15:0], mag_y [31:16], mag_z [47:32]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;          // bearing [15:0]
    logic        m_tuser;          // invalid_reading [0]

    t_heading heading_q[$];
    t_heading want;
    int       err_cnt = 0;
    int       n_sent = 0;
    int       n_rcvd = 0;
    int       n_flagged = 0;
    bit       tx_gapless = 1'b0;
    bit       rx_gapless = 1'b0;

    compass_bearing_with_stuck_check_top #(
        .CORDIC_STAGES    (STAGES),
        .BEARING_FRAC_BITS(FRAC_BITS)
    ) u_dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(s_tready),
        .i_s_tdata (s_tdata),
        .o_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata (m_tdata),
        .o_m_tuser (m_tuser)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("tb_top failed");
        $finish;
    end

    function automatic logic [15:0] cordic_bearing(logic signed [15:0] mx,
                                                   logic signed [15:0] my);
        longint x, y, ax, ay, mag, xs, ys;
        longint unsigned rounded;
        logic [31:0] ang;
        int sh;
        x = mx;
        y = my;
        ang = '0;
        sh = 0;
        if (x == 0 && y == 0) begin
            return 16'd0;
        end
        if (x < 0) begin
            x = -x;
            y = -y;
            ang = HALF_TURN;
        end
        ax = x;
        ay = (y < 0) ? -y : y;
        mag = (ax > ay) ? ax : ay;
        while (sh < 29 && (mag << sh) < (longint'(1) << 29)) begin
            sh++;
        end
        x = x <<< sh;
        y = y <<< sh;
        for (int i = 0; i < STAGES && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                ang = ang + ATAN_BAM[i];
            end else begin
                x = x - ys;
                y = y + xs;
                ang = ang - ATAN_BAM[i];
            end
        end
        rounded = (longint'({32'd0, ang}) * FULL_TURN + 64'h8000_0000) >> 32;
        if (rounded >= FULL_TURN) begin
            rounded = 0;
        end
        return rounded[15:0];
    endfunction

    function automatic logic is_stuck(logic signed [15:0] x, logic signed [15:0] y,
                                      logic signed [15:0] z);
        if (x != y || y != z) begin
            return 1'b0;
        end
        return x == STUCK_NEG_MID || x == STUCK_POS_MID || x == STUCK_NEG_HIGH || x == 0;
    endfunction

    task automatic send_sample(logic signed [15:0] x, logic signed [15:0] y,
                               logic signed [15:0] z);
        int gap;
        t_heading h;
        gap = tx_gapless ? 0 : $urandom_range(0, 6);
        @(negedge clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x};
        do @(posedge clk); while (!s_tready);
        h.bearing = cordic_bearing(x, y);
        h.invalid = is_stuck(x, y, z);
        heading_q.push_back(h);
        n_sent++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (heading_q.size() != 0) @(posedge clk);
    endtask

    // receiver: random hold-off before each transfer
    initial begin
        int gap;
        wait (rst_n);
        forever begin
            gap = rx_gapless ? 0 : $urandom_range(0, 6);
            @(negedge clk);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            n_rcvd++;
            if (heading_q.size() == 0) begin
                $error("unexpected transfer: bearing=%0d invalid=%0b", m_tdata, m_tuser);
                err_cnt++;
            end else begin
                want = heading_q.pop_front();
                if (m_tdata !== want.bearing) begin
                    $error("bearing: expected %0d, got %0d", want.bearing, m_tdata);
                    err_cnt++;
                end
                if (m_tuser !== want.invalid) begin
                    $error("invalid_reading: expected %0b, got %0b", want.invalid, m_tuser);
                    err_cnt++;
                end
                if (want.invalid) begin
                    n_flagged++;
                end
            end
        end
    end

    task automatic test_directed();
        send_sample(16'sd0, 16'sd0, 16'sd0);            // zero vector, stuck at zero
        send_sample(16'sd0, 16'sd0, 16'sd5);            // zero vector, not stuck
        send_sample(16'sd0, 16'sd0, -16'sd32768);
        send_sample(STUCK_NEG_MID, STUCK_NEG_MID, STUCK_NEG_MID);
        send_sample(STUCK_POS_MID, STUCK_POS_MID, STUCK_POS_MID);
        send_sample(STUCK_NEG_HIGH, STUCK_NEG_HIGH, STUCK_NEG_HIGH);
        send_sample(STUCK_POS_MID, STUCK_POS_MID, 16'sd16447);
        send_sample(STUCK_NEG_HIGH, STUCK_NEG_HIGH, -16'sd32639);
        send_sample(STUCK_NEG_MID, STUCK_NEG_MID, 16'sd16192);
        send_sample(16'sd1, 16'sd0, 16'sd0);
        send_sample(-16'sd1, 16'sd0, 16'sd0);
        send_sample(16'sd0, 16'sd1, 16'sd0);
        send_sample(16'sd0, -16'sd1, 16'sd0);
        send_sample(16'sd32767, -16'sd1, 16'sd0);       // rounds up to a full turn
        send_sample(16'sd32767, 16'sd1, 16'sd0);
        send_sample(-16'sd32768, -16'sd1, 16'sd0);
        send_sample(-16'sd32768, 16'sd1, 16'sd0);
        send_sample(-16'sd32768, -16'sd32768, -16'sd32768);
        send_sample(16'sd32767, 16'sd32767, 16'sd32767);
        send_sample(-16'sd32768, 16'sd32767, 16'sd0);
        send_sample(16'sd32767, -16'sd32768, 16'sd0);
        send_sample(16'sd0, -16'sd32768, 16'sd32767);
        send_sample(-16'sd1, -16'sd1, -16'sd1);
        send_sample(-16'sd1, 16'sd1, 16'sd0);
        send_sample(16'sd1, -16'sd1, 16'sd0);
    endtask

    task automatic test_random_uniform(int n);
        repeat (n) begin
            send_sample(16'($urandom), 16'($urandom), 16'($urandom));
        end
    endtask

    task automatic test_small_vectors(int n);
        logic signed [15:0] x, y;
        repeat (n) begin
            x = 16'($urandom_range(0, 32767) >> $urandom_range(0, 15));
            y = 16'($urandom_range(0, 32767) >> $urandom_range(0, 15));
            if ($urandom_range(0, 1)) x = -x;
            if ($urandom_range(0, 1)) y = -y;
            send_sample(x, y, 16'($urandom));
        end
    endtask

    task automatic test_stuck_patterns(int n);
        logic signed [15:0] p, x, y, z;
        repeat (n) begin
            case ($urandom_range(0, 3))
                0: p = STUCK_NEG_MID;
                1: p = STUCK_POS_MID;
                2: p = STUCK_NEG_HIGH;
                default: p = 16'sd0;
            endcase
            x = p;
            y = p;
            z = p;
            // break the pattern on one axis now and then
            case ($urandom_range(0, 5))
                0: x = p ^ (16'sd1 << $urandom_range(0, 15));
                1: y = p ^ (16'sd1 << $urandom_range(0, 15));
                2: z = p ^ (16'sd1 << $urandom_range(0, 15));
                default: ;
            endcase
            send_sample(x, y, z);
        end
    endtask

    task automatic test_streaming(int n);
        tx_gapless = 1'b1;
        rx_gapless = 1'b1;
        test_random_uniform(n / 2);
        rx_gapless = 1'b0;
        test_random_uniform(n / 2);
        tx_gapless = 1'b0;
        rx_gapless = 1'b1;
        test_small_vectors(n / 4);
        rx_gapless = 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        wait_idle();
        test_random_uniform(450);
        wait_idle();
        test_small_vectors(150);
        test_stuck_patterns(100);
        wait_idle();
        test_streaming(200);
        wait_idle();
        repeat (LATENCY + 8) @(posedge clk);

        $display("Sent %0d samples, checked %0d results (%0d flagged stuck).",
                 n_sent, n_rcvd, n_flagged);
        $display("Covered corners, zero vector, full-turn wrap, stuck patterns, and streams.");
        if (err_cnt == 0 && heading_q.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
